// ===== rtl/triangle_min_angle_defines.svh =====
// assertion macros shared by the checker of the triangle minimum angle block
`ifndef TRIANGLE_MIN_ANGLE_DEFINES_SVH
`define TRIANGLE_MIN_ANGLE_DEFINES_SVH

// property checked on every rising edge outside reset
`define TMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define TMA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/tma_pkg.sv =====
// shared widths, types and the arctangent table of the triangle minimum angle block
`default_nettype none
package tma_pkg;
    localparam int COORD_W   = 24;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int MAG_W     = PROD_W + 1;
    localparam int POS_W     = $clog2(MAG_W);
    localparam int NORM_POS  = 29;
    localparam int CW        = 33;
    localparam int ZW        = 27;
    localparam int STEPS     = 23;
    localparam int ANG_W     = 24;
    localparam int OUT_W     = 16;
    localparam int LAT       = 30;
    localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

    // one corner after the dot and cross products
    typedef struct packed {
        logic [MAG_W-1:0] px;
        logic [MAG_W-1:0] py;
        logic             obtuse;
        logic             fix90;
    } corner_t;

    // one corner on its way through the rotation stages
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 obtuse;
        logic                 fix90;
    } cord_t;

    // atan(2^-i) in degrees * 65536, rounded
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/tma_edge.sv =====
// edge vectors, dot and cross products of one corner over three stages
`default_nettype none
module tma_edge
    import tma_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [COORD_W-1:0] ox,
    input  wire logic signed [COORD_W-1:0] oy,
    input  wire logic signed [COORD_W-1:0] ux_end,
    input  wire logic signed [COORD_W-1:0] uy_end,
    input  wire logic signed [COORD_W-1:0] vx_end,
    input  wire logic signed [COORD_W-1:0] vy_end,
    output corner_t                        corner
);
    logic signed [EDGE_W-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [EDGE_W-1:0] ux_next, uy_next, vx_next, vy_next;
    logic                     zero1_reg, zero2_reg;
    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic signed [MAG_W-1:0]  dot, cr;
    logic [MAG_W-1:0]         acr;
    corner_t                  corner_reg, corner_next;

    // edge differences
    always_comb
    begin
        ux_next = EDGE_W'(ux_end) - EDGE_W'(ox);
        uy_next = EDGE_W'(uy_end) - EDGE_W'(oy);
        vx_next = EDGE_W'(vx_end) - EDGE_W'(ox);
        vy_next = EDGE_W'(vy_end) - EDGE_W'(oy);
    end

    // dot and cross, then fold into the first quadrant
    always_comb
    begin
        dot = MAG_W'(pxx_reg) + MAG_W'(pyy_reg);
        cr  = MAG_W'(pxy_reg) - MAG_W'(pyx_reg);
        acr = cr[MAG_W-1] ? MAG_W'(-cr) : MAG_W'(cr);
        corner_next.fix90 = zero2_reg;
        if (!dot[MAG_W-1])
        begin
            corner_next.px     = MAG_W'(dot);
            corner_next.py     = acr;
            corner_next.obtuse = 1'b0;
        end
        else
        begin
            corner_next.px     = acr;
            corner_next.py     = MAG_W'(-dot);
            corner_next.obtuse = 1'b1;
        end
    end

    // three register stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg     <= ux_next;
            uy_reg     <= uy_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            zero1_reg  <= (ux_next == '0 && uy_next == '0) ||
                          (vx_next == '0 && vy_next == '0);
            pxx_reg    <= ux_reg * vx_reg;
            pyy_reg    <= uy_reg * vy_reg;
            pxy_reg    <= ux_reg * vy_reg;
            pyx_reg    <= uy_reg * vx_reg;
            zero2_reg  <= zero1_reg;
            corner_reg <= corner_next;
        end
    end

    assign corner = corner_reg;
endmodule
`default_nettype wire

// ===== rtl/tma_norm.sv =====
// scales a corner vector so that its larger component lies in [2^29, 2^30)
`default_nettype none
module tma_norm
    import tma_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire corner_t corner,
    output cord_t        cord
);
    corner_t          c_reg, c_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [MAG_W-1:0] m;
    logic             zero_next;
    logic [MAG_W-1:0] sx, sy;
    cord_t            cord_reg, cord_next;

    // leading one of the larger component
    always_comb
    begin
        m = (corner.px > corner.py) ? corner.px : corner.py;
        zero_next = (m == '0);
        pos_next = '0;
        for (int j = 0; j < MAG_W; j++)
        begin
            if (m[j])
                pos_next = POS_W'(j);
        end
        c_next       = corner;
        c_next.fix90 = corner.fix90 | zero_next;
    end

    // shift both components by the same amount
    always_comb
    begin
        if (pos_reg >= POS_W'(NORM_POS))
        begin
            sx = c_reg.px >> (pos_reg - POS_W'(NORM_POS));
            sy = c_reg.py >> (pos_reg - POS_W'(NORM_POS));
        end
        else
        begin
            sx = c_reg.px << (POS_W'(NORM_POS) - pos_reg);
            sy = c_reg.py << (POS_W'(NORM_POS) - pos_reg);
        end
        cord_next.x      = CW'(sx[NORM_POS:0]);
        cord_next.y      = CW'(sy[NORM_POS:0]);
        cord_next.z      = '0;
        cord_next.obtuse = c_reg.obtuse;
        cord_next.fix90  = c_reg.fix90;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg    <= c_next;
            pos_reg  <= pos_next;
            cord_reg <= cord_next;
        end
    end

    assign cord = cord_reg;
endmodule
`default_nettype wire

// ===== rtl/tma_cordic.sv =====
// vectoring rotations, one register stage per step, angle in degrees * 65536
`default_nettype none
module tma_cordic
    import tma_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire cord_t cord_in,
    output cord_t      cord_out
);
    cord_t st_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        cord_t                src, nxt;
        logic signed [CW-1:0] xs, ys;

        if (i == 0)
        begin : g_first
            assign src = cord_in;
        end
        else
        begin : g_rest
            assign src = st_reg[i-1];
        end

        // rotate towards the x axis
        always_comb
        begin
            xs  = src.x >>> i;
            ys  = src.y >>> i;
            nxt = src;
            if (src.y > 0)
            begin
                nxt.x = src.x + ys;
                nxt.y = src.y - xs;
                nxt.z = src.z + atan_deg(i);
            end
            else if (src.y < 0)
            begin
                nxt.x = src.x - ys;
                nxt.y = src.y + xs;
                nxt.z = src.z - atan_deg(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[i] <= nxt;
        end
    end

    assign cord_out = st_reg[STEPS-1];
endmodule
`default_nettype wire

// ===== rtl/triangle_min_angle.sv =====
// top level of the triangle minimum interior angle pipeline
//
//  port group                         dir  role
//  in_valid/in_ready, ax..cy          in   one triangle, three Q11.12 vertices
//  out_valid/out_ready, least_angle,  out  smallest angle Q8.8 degrees and
//  degenerate                              zero-edge flag
//
// one triangle per cycle while out_ready does not hold the pipeline; register stages in order:
// edges and products, scaling, 23 rotation steps, offset and clamp, then the minimum.
// reset clears only the valid bits.
// the whole pipeline holds while a result waits and out_ready is low;
// in_ready is low in exactly those cycles.
`default_nettype none
module triangle_min_angle
    import tma_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] ax,
    input  wire logic signed [COORD_W-1:0] ay,
    input  wire logic signed [COORD_W-1:0] bx,
    input  wire logic signed [COORD_W-1:0] by,
    input  wire logic signed [COORD_W-1:0] cx,
    input  wire logic signed [COORD_W-1:0] cy,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [OUT_W-1:0]               least_angle,
    output logic                           degenerate
);
    logic                 en;
    logic                 vld_reg   [LAT];
    logic                 degen_reg [LAT];
    logic                 degen_next;
    corner_t              corner [3];
    cord_t                cn [3];
    cord_t                cd [3];
    logic [ANG_W-1:0]     ang_reg  [3];
    logic [ANG_W-1:0]     ang_next [3];
    logic signed [ZW-1:0] zs [3];
    logic [ANG_W-1:0]     amin;
    logic [ANG_W-1:0]     rnd;
    logic [OUT_W-1:0]     least_angle_reg;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    assign degen_next = (bx == ax && by == ay) || (cx == ax && cy == ay) ||
                        (cx == bx && cy == by);

    // three corners, each with its own chain
    tma_edge u_edge0 (.clk(clk), .en(en), .ox(ax), .oy(ay), .ux_end(bx), .uy_end(by),
                      .vx_end(cx), .vy_end(cy), .corner(corner[0]));
    tma_edge u_edge1 (.clk(clk), .en(en), .ox(bx), .oy(by), .ux_end(ax), .uy_end(ay),
                      .vx_end(cx), .vy_end(cy), .corner(corner[1]));
    tma_edge u_edge2 (.clk(clk), .en(en), .ox(cx), .oy(cy), .ux_end(bx), .uy_end(by),
                      .vx_end(ax), .vy_end(ay), .corner(corner[2]));

    for (genvar k = 0; k < 3; k++)
    begin : g_corner
        tma_norm   u_norm   (.clk(clk), .en(en), .corner(corner[k]), .cord(cn[k]));
        tma_cordic u_cordic (.clk(clk), .en(en), .cord_in(cn[k]), .cord_out(cd[k]));

        // quadrant offset, zero-vector case and clamp
        always_comb
        begin
            zs[k] = cd[k].z + (cd[k].obtuse ? DEG90 : ZW'(0));
            if (cd[k].fix90)
                ang_next[k] = ANG_W'(DEG90);
            else if (zs[k] < 0)
                ang_next[k] = '0;
            else if (zs[k] > DEG180)
                ang_next[k] = ANG_W'(DEG180);
            else
                ang_next[k] = ANG_W'(zs[k]);
        end
    end

    // minimum and rounding to Q8.8
    always_comb
    begin
        amin = ang_reg[0];
        if (ang_reg[1] < amin)
            amin = ang_reg[1];
        if (ang_reg[2] < amin)
            amin = ang_reg[2];
        rnd = amin + ANG_W'(128);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                ang_reg[k] <= ang_next[k];
            least_angle_reg <= rnd[OUT_W+7:8];
            degen_reg[0]    <= degen_next;
            for (int s = 1; s < LAT; s++)
                degen_reg[s] <= degen_reg[s-1];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    assign out_valid   = vld_reg[LAT-1];
    assign least_angle = least_angle_reg;
    assign degenerate  = degen_reg[LAT-1];
endmodule
`default_nettype wire

// ===== rtl/tma_checker.sv =====
// port-level checks of the triangle minimum angle block and their binding
`default_nettype none
`include "triangle_min_angle_defines.svh"
module tma_checker
    import tma_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [OUT_W-1:0] least_angle,
    input wire logic             degenerate
);
    // result never beyond 180 degrees
    `TMA_ASSERT(a_range, !out_valid || least_angle <= OUT_W'(46080), "angle above 180")
    // a waiting result blocks new items
    `TMA_ASSERT(a_hold_in, !(out_valid && !out_ready && in_ready), "ready while stalled")
    // free output side means input is taken
    `TMA_ASSERT(a_free, out_valid || in_ready, "input blocked with empty output")
    // a result that is not taken stays with its payload
    `TMA_ASSERT_IMP(a_stay, out_valid && !out_ready,
                    out_valid && $stable(least_angle) && $stable(degenerate), "result dropped")
endmodule

bind triangle_min_angle tma_checker u_tma_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .least_angle(least_angle), .degenerate(degenerate)
);
`default_nettype wire

// ===== tb/tb_triangle_min_angle.sv =====
// testbench for the triangle minimum interior angle pipeline
`default_nettype none
module tb_triangle_min_angle;
    import tma_pkg::*;

    localparam int WATCHDOG = 2000;

    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
        logic                      pause;
    } tri_item_t;

    typedef struct {
        logic [OUT_W-1:0] angle;
        logic             degen;
    } angle_res_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
    logic out_valid;
    logic out_ready;
    logic [OUT_W-1:0] least_angle;
    logic degenerate;

    tri_item_t  pending_tris[$];
    angle_res_t expected_angles[$];
    int mismatches;
    int idle_cycles;
    bit stim_done;
    int send_wait;
    int recv_wait;

    triangle_min_angle i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
        .out_valid(out_valid), .out_ready(out_ready),
        .least_angle(least_angle), .degenerate(degenerate)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // atan(2^-i) in degrees * 65536
    function automatic longint atan_step(input int i);
        longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1};
        return t[i];
    endfunction

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // halve both magnitudes until below 2^30, sign kept
    function automatic void shrink_edge(inout longint x, inout longint y);
        while (magnitude(x) >= (64'sd1 << 30) || magnitude(y) >= (64'sd1 << 30))
        begin
            x = (x < 0) ? -(magnitude(x) >>> 1) : (x >>> 1);
            y = (y < 0) ? -(magnitude(y) >>> 1) : (y >>> 1);
        end
    endfunction

    // corner angle in degrees * 65536
    function automatic longint corner_deg(input longint ux, input longint uy,
                                          input longint vx, input longint vy);
        longint dot, cr, base, z, x, y, xs, ys;
        longint unsigned px, py, m;
        if ((ux == 0 && uy == 0) || (vx == 0 && vy == 0))
            return 90 * 65536;
        shrink_edge(ux, uy);
        shrink_edge(vx, vy);
        dot = ux * vx + uy * vy;
        cr = magnitude(ux * vy - uy * vx);
        if (dot >= 0)
        begin
            px = dot; py = cr; base = 0;
        end
        else
        begin
            px = cr; py = -dot; base = 90 * 65536;
        end
        m = px > py ? px : py;
        if (m == 0)
            return 90 * 65536;
        while (m >= (64'd1 << 30))
        begin
            px >>= 1; py >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            px <<= 1; py <<= 1; m <<= 1;
        end
        x = px;
        y = py;
        z = 0;
        // vectoring rotation, floor shifts
        for (int i = 0; i < 23; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z += atan_step(i);
            end
            else if (y < 0)
            begin
                x = x - ys; y = y + xs; z -= atan_step(i);
            end
        end
        z += base;
        if (z < 0) z = 0;
        if (z > 180 * 65536) z = 180 * 65536;
        return z;
    endfunction

    function automatic angle_res_t smallest_angle(input tri_item_t t);
        angle_res_t r;
        longint a0, a1, a2, amin;
        longint pax, pay, pbx, pby, pcx, pcy;
        pax = t.ax; pay = t.ay; pbx = t.bx; pby = t.by; pcx = t.cx; pcy = t.cy;
        r.degen = (pbx == pax && pby == pay) || (pcx == pax && pcy == pay) ||
                  (pcx == pbx && pcy == pby);
        a0 = corner_deg(pbx - pax, pby - pay, pcx - pax, pcy - pay);
        a1 = corner_deg(pax - pbx, pay - pby, pcx - pbx, pcy - pby);
        a2 = corner_deg(pbx - pcx, pby - pcy, pax - pcx, pay - pcy);
        amin = a0;
        if (a1 < amin) amin = a1;
        if (a2 < amin) amin = a2;
        r.angle = OUT_W'((amin + 128) >>> 8);
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(input int kind);
        case (kind)
            0: return COORD_W'($urandom);
            1: return COORD_W'($signed($urandom_range(0, 4000)) - 2000);
            2: return COORD_W'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom_range(0, 1) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                  : {1'b1, {(COORD_W-1){1'b0}}};
        endcase
    endfunction

    function automatic tri_item_t make_tri(input int x0, input int y0, input int x1,
                                           input int y1, input int x2, input int y2);
        tri_item_t t;
        t.ax = COORD_W'(x0); t.ay = COORD_W'(y0);
        t.bx = COORD_W'(x1); t.by = COORD_W'(y1);
        t.cx = COORD_W'(x2); t.cy = COORD_W'(y2);
        t.pause = 1'b0;
        return t;
    endfunction

    // stimulus
    initial
    begin
        tri_item_t t;
        int kind;
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, zero edges, collinear, right angle
        pending_tris = {pending_tris, make_tri(0, 0, 0, 0, 0, 0)};
        pending_tris = {pending_tris, make_tri(mx, mx, mx, mx, mx, mx)};
        pending_tris = {pending_tris, make_tri(mn, mn, mx, mx, mn, mx)};
        pending_tris = {pending_tris, make_tri(mx, mn, mn, mx, mx, mx)};
        pending_tris = {pending_tris, make_tri(mn, mn, mn, mn, mx, mx)};
        pending_tris = {pending_tris, make_tri(0, 0, 4096, 0, 4096, 0)};
        pending_tris = {pending_tris, make_tri(0, 0, 4096, 0, 8192, 0)};
        pending_tris = {pending_tris, make_tri(mn, mn, 0, 0, mx, mx)};
        pending_tris = {pending_tris, make_tri(0, 0, 4096, 0, 0, 4096)};
        pending_tris = {pending_tris, make_tri(0, 0, 4096, 0, 2048, 3547)};
        pending_tris = {pending_tris, make_tri(0, 0, mx, 0, mx, 1)};
        pending_tris = {pending_tris, make_tri(0, 0, 1, 0, 0, mx)};
        pending_tris = {pending_tris, make_tri(-1, -1, 1, 1, -1, 1)};
        pending_tris = {pending_tris, make_tri(mn, 0, mx, 0, 0, 1)};
        pending_tris = {pending_tris, make_tri(0, mn, 0, mx, 1, 0)};
        pending_tris = {pending_tris, make_tri(-1, -1, -1, -1, 0, 0)};
        // random triangles, with a drain pause now and then
        for (int n = 0; n < 1800; n++)
        begin
            kind = $urandom_range(0, 9);
            t.ax = rand_coord(kind % 4);
            t.ay = rand_coord(kind % 4);
            t.bx = rand_coord(kind % 4);
            t.by = rand_coord(kind % 4);
            t.cx = rand_coord(kind % 4);
            t.cy = rand_coord(kind % 4);
            if (kind == 9)
            begin
                // force a shared vertex or collinear points
                if ($urandom_range(0, 1))
                begin
                    t.cx = t.ax; t.cy = t.ay;
                end
                else
                begin
                    t.cx = t.bx + (t.bx - t.ax); t.cy = t.by + (t.by - t.ay);
                end
            end
            t.pause = (n % 600 == 300);
            pending_tris = {pending_tris, t};
        end
        wait (pending_tris.size() == 0);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {ax, ay, bx, by, cx, cy} <= '0;
            send_wait <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold the item until taken
        end
        else if (send_wait > 0)
        begin
            in_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pending_tris.size() > 0 &&
                 !(pending_tris[0].pause && expected_angles.size() > 0))
        begin
            t_send(pending_tris[0]);
            pending_tris.delete(0);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    task automatic t_send(input tri_item_t t);
        in_valid <= 1'b1;
        ax <= t.ax; ay <= t.ay; bx <= t.bx; by <= t.by; cx <= t.cx; cy <= t.cy;
        expected_angles = {expected_angles, smallest_angle(t)};
        send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
    endtask

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        angle_res_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            mismatches <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: least_angle %0d degenerate %0d",
                                 least_angle, degenerate);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    e = expected_angles[0];
                    expected_angles.delete(0);
                    if (e.angle !== least_angle || e.degen !== degenerate)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected %0d/%0d, got %0d/%0d",
                                     e.angle, e.degen, least_angle, degenerate);
                        mismatches <= mismatches + 1;
                    end
                end
                recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // end of run and watchdog
    initial
    begin
        wait (stim_done);
        @(posedge clk);
        while (expected_angles.size() > 0 && idle_cycles < WATCHDOG)
            @(posedge clk);
        repeat (LAT + 10) @(posedge clk);
        if (idle_cycles >= WATCHDOG)
            $display("FAILED: results differ");
        else if (mismatches == 0 && expected_angles.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG);
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/tma_pkg.sv
rtl/tma_edge.sv
rtl/tma_norm.sv
rtl/tma_cordic.sv
rtl/triangle_min_angle.sv
rtl/tma_checker.sv
tb/tb_triangle_min_angle.sv
